/* design/aorf_pkg.sv */
package aorf_pkg;

  // Register map, index i sits at byte address 4*i
  typedef enum logic [2:0] {
    REG_LIMIT_LOW   = 3'd0,
    REG_LIMIT_HIGH  = 3'd1,
    REG_STEP_THRESH = 3'd2,
    REG_SIGMA       = 3'd3,
    REG_WEIGHT      = 3'd4,
    REG_OUTLIER     = 3'd5,
    REG_FILTER      = 3'd6
  } reg_idx_e;

  // Outlier check selection
  localparam logic [2:0] OM_NONE  = 3'd0;
  localparam logic [2:0] OM_LIMIT = 3'd1;
  localparam logic [2:0] OM_GRAD  = 3'd2;
  localparam logic [2:0] OM_SIGMA = 3'd3;
  localparam logic [2:0] OM_ALL   = 3'd4;

  // Filter selection
  localparam logic [1:0] FM_NONE   = 2'd0;
  localparam logic [1:0] FM_AVG    = 2'd1;
  localparam logic [1:0] FM_MEDIAN = 2'd2;
  localparam logic [1:0] FM_LOWPASS = 2'd3;

  // Shared divider and multiplier run one bit per cycle over 64 bits
  localparam logic [5:0] ITER_LAST = 6'd63;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PREP,
    S_SIG_DIV,
    S_SIG_M1,
    S_SIG_M2,
    S_SEL,
    S_ST_DIV,
    S_ST_D2,
    S_ST_MUL,
    S_ST_ACC,
    S_FILT,
    S_SCAN,
    S_AVG_DIV,
    S_MED_RD,
    S_MED_VI,
    S_MED_CHK,
    S_LP_M1,
    S_LP_M2,
    S_LP_FIN,
    S_DONE
  } state_e;

endpackage

/* design/adc_outlier_reject_and_filter.sv */
// Work per beat: the n-sigma check when it runs (a divide and two multiplies), then the
//   statistics update (a divide and a multiply), then the moving average, the median or
//   the low-pass filter.
// Throughput: one beat at a time; the shared bit-serial divider/multiplier and the single
//   read port of the window memory serialise the work. A finished beat waits in the output
//   register while the next one is accepted.
// Reset: control and configuration registers take their reset values; per-channel state
//   reads as its reset value through one valid bit per channel, so no clearing pass.
module adc_outlier_reject_and_filter #(
  parameter int CHANNELS          = 8,
  parameter int WINDOW            = 16,
  parameter int MAX_HISTORY       = 256,
  parameter int MIN_SIGMA_SAMPLES = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [2:0] channel, [26:3] sample, [31:27] zero
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [2:0] out_channel, [26:3] filtered_result, [31:27] zero
  output logic        m_axis_tuser,   // [0] outlier_flag
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CH_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SL_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int WCNT_W  = $clog2(WINDOW + 1);
  localparam int CNT_W   = $clog2(MAX_HISTORY + 1);
  localparam int DV_W    = (CNT_W > WCNT_W) ? CNT_W : WCNT_W;
  localparam int WDEPTH  = CHANNELS * WINDOW;
  localparam int WA_W    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int SUM_W   = 24 + WCNT_W;

  typedef struct packed {
    logic [SL_W-1:0]    slot;
    logic               full;
    logic [CNT_W-1:0]   cnt;
    logic signed [47:0] mean;
    logic [63:0]        spread;
    logic signed [23:0] prev_raw;
    logic signed [23:0] last_good;
    logic signed [23:0] prev_out;
  } chst_t;

  localparam chst_t CHST_RST = '{
    slot: SL_W'(WINDOW - 1), full: 1'b0, cnt: '0, mean: '0, spread: '0,
    prev_raw: '0, last_good: '0, prev_out: '0
  };

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [23:0] lim_lo_q, lim_hi_q;
  logic [23:0]        step_q;
  logic [15:0]        sf_q;
  logic [16:0]        sw_q;
  logic [2:0]         om_q;
  logic [1:0]         fm_q;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_lo_q <= 24'sh800000;
      lim_hi_q <= 24'sh7fffff;
      step_q   <= 24'hffffff;
      sf_q     <= 16'd768;
      sw_q     <= 17'd32768;
      om_q     <= aorf_pkg::OM_NONE;
      fm_q     <= aorf_pkg::FM_NONE;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        aorf_pkg::REG_LIMIT_LOW:   lim_lo_q <= pwdata[23:0];
        aorf_pkg::REG_LIMIT_HIGH:  lim_hi_q <= pwdata[23:0];
        aorf_pkg::REG_STEP_THRESH: step_q   <= pwdata[23:0];
        aorf_pkg::REG_SIGMA:       sf_q     <= pwdata[15:0];
        aorf_pkg::REG_WEIGHT:      sw_q     <= pwdata[16:0];
        aorf_pkg::REG_OUTLIER:     om_q     <= pwdata[2:0];
        aorf_pkg::REG_FILTER:      fm_q     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      aorf_pkg::REG_LIMIT_LOW:   prdata = {8'd0, lim_lo_q};
      aorf_pkg::REG_LIMIT_HIGH:  prdata = {8'd0, lim_hi_q};
      aorf_pkg::REG_STEP_THRESH: prdata = {8'd0, step_q};
      aorf_pkg::REG_SIGMA:       prdata = {16'd0, sf_q};
      aorf_pkg::REG_WEIGHT:      prdata = {15'd0, sw_q};
      aorf_pkg::REG_OUTLIER:     prdata = {29'd0, om_q};
      aorf_pkg::REG_FILTER:      prdata = {30'd0, fm_q};
      default:                   prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Storage: per-channel state record and the window rings
  // ---------------------------------------------------------------------------
  chst_t              cs_mem [CHANNELS];
  chst_t              cs_rdata_q, cs_wdata;
  logic               cs_re, cs_we;
  logic [CH_AW-1:0]   cs_raddr, ch_idx;
  logic [CHANNELS-1:0] chv_q;

  logic signed [23:0] win_mem [WDEPTH];
  logic signed [23:0] win_rdata_q;
  logic               win_re, win_we;
  logic [WA_W-1:0]    win_raddr, win_waddr, win_base;

  always_ff @(posedge clk_i) begin
    if (cs_we) cs_mem[ch_idx] <= cs_wdata;
    if (cs_re) cs_rdata_q <= cs_mem[cs_raddr];
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  aorf_pkg::state_e state_q, state_d;

  logic [2:0]          ch_q, ch_d;
  logic signed [23:0]  x_q, x_d, v_q, v_d, res_q, res_d, vi_q, vi_d;
  logic                flag_q, flag_d, pass_q, pass_d, dneg_q, dneg_d, sneg_q, sneg_d;
  logic                rdv_q, rdv_d;
  chst_t               st_q, st_d, st_v;
  logic [48:0]         dmag_q, dmag_d;
  logic [CNT_W-1:0]    n_q, n_d;
  logic [97:0]         prod1_q, prod1_d;
  logic [63:0]         inc_q, inc_d;
  logic [WCNT_W-1:0]   wcnt_q, wcnt_d, idx_q, idx_d, i_q, i_d;
  logic [WCNT_W-1:0]   less_q, less_d, le_q, le_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic signed [42:0]  lp_q, lp_d;

  // Bit-serial divider and multiplier, shared
  logic [5:0]          it_q, it_d;
  logic [DV_W-1:0]     dv_rem_q, dv_rem_d, dv_dvs_q, dv_dvs_d, dv_rem_nx;
  logic [63:0]         dv_quo_q, dv_quo_d, dv_quo_nx;
  logic [DV_W:0]       dv_sh;
  logic                dv_ge;
  logic [63:0]         mu_a_q, mu_a_d, mu_hi_q, mu_hi_d, mu_lo_q, mu_lo_d;
  logic [63:0]         mu_hi_nx, mu_lo_nx;
  logic [64:0]         mu_sum;

  // Datapath helpers
  logic signed [48:0]  xs49, d49, d2_49, mean_nx49, q49;
  logic signed [24:0]  gdiff;
  logic [24:0]         gmag;
  logic                lim_hit, grad_hit, sig_need;
  logic [31:0]         s2;
  logic [64:0]         spread_sum65;
  logic [SL_W-1:0]     slot_nx;
  logic                full_nx;
  logic [16:0]         w_eff, lp_w;
  logic signed [23:0]  lp_opd;
  logic signed [42:0]  lp_mul, lp_adj;
  logic [WCNT_W-1:0]   med_k;
  logic [SUM_W-1:0]    sum_mag;
  logic [63:0]         q_neg;

  logic                out_vld_q;
  logic [2:0]          out_ch_q;
  logic signed [23:0]  out_val_q;
  logic                out_flag_q;
  logic                out_load;

  always_ff @(posedge clk_i) begin
    if (win_we) win_mem[win_waddr] <= v_q;
    if (win_re) win_rdata_q <= win_mem[win_raddr];
  end

  assign ch_idx   = CH_AW'(ch_q);
  assign win_base = WA_W'(int'(ch_idx) * WINDOW);
  assign st_v     = chv_q[ch_idx] ? cs_rdata_q : CHST_RST;

  assign dv_sh     = {dv_rem_q, dv_quo_q[63]};
  assign dv_ge     = dv_sh >= {1'b0, dv_dvs_q};
  assign dv_rem_nx = dv_ge ? DV_W'(dv_sh - {1'b0, dv_dvs_q}) : dv_sh[DV_W-1:0];
  assign dv_quo_nx = {dv_quo_q[62:0], dv_ge};
  assign mu_sum    = {1'b0, mu_hi_q} + (mu_lo_q[0] ? {1'b0, mu_a_q} : 65'd0);
  assign mu_hi_nx  = mu_sum[64:1];
  assign mu_lo_nx  = {mu_sum[0], mu_lo_q[63:1]};
  assign q_neg     = 64'd0 - dv_quo_nx;

  assign xs49     = {{9{x_q[23]}}, x_q, 16'h0000};
  assign d49      = xs49 - {st_v.mean[47], st_v.mean};
  assign q49      = dneg_q ? $signed(q_neg[48:0]) : $signed(dv_quo_nx[48:0]);
  assign mean_nx49 = {st_q.mean[47], st_q.mean} + q49;
  assign d2_49    = xs49 - {st_q.mean[47], st_q.mean};
  assign gdiff    = {x_q[23], x_q} - {st_v.prev_raw[23], st_v.prev_raw};
  assign gmag     = gdiff[24] ? 25'(-gdiff) : gdiff;
  assign s2       = sf_q * sf_q;

  // Outlier checks in turn: limit, then gradient, then n-sigma
  assign lim_hit  = (om_q == aorf_pkg::OM_LIMIT || om_q == aorf_pkg::OM_ALL) &&
                    (x_q < lim_lo_q || x_q > lim_hi_q);
  assign grad_hit = !lim_hit &&
                    (om_q == aorf_pkg::OM_GRAD || om_q == aorf_pkg::OM_ALL) &&
                    (st_v.cnt != '0) && (gmag > {1'b0, step_q});
  assign sig_need = !lim_hit && !grad_hit &&
                    (om_q == aorf_pkg::OM_SIGMA || om_q == aorf_pkg::OM_ALL) &&
                    (int'(st_v.cnt) >= MIN_SIGMA_SAMPLES);

  assign spread_sum65 = {1'b0, st_q.spread} + {1'b0, inc_q};
  assign slot_nx = (st_q.slot == SL_W'(WINDOW - 1)) ? '0 : st_q.slot + 1'b1;
  assign full_nx = st_q.full | (slot_nx == SL_W'(WINDOW - 1));

  // One multiplier serves both low-pass terms
  assign w_eff  = (sw_q > 17'h10000) ? 17'h10000 : sw_q;
  assign lp_w   = (state_q == aorf_pkg::S_LP_M1) ? w_eff : 17'h10000 - w_eff;
  assign lp_opd = (state_q == aorf_pkg::S_LP_M1) ? v_q : st_q.prev_out;
  assign lp_mul = $signed({1'b0, lp_w}) * lp_opd;
  assign lp_adj = lp_q[42] ? lp_q + 43'sd65535 : lp_q;

  assign med_k   = wcnt_q >> 1;
  assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  assign out_load = (state_q == aorf_pkg::S_DONE) && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = (state_q == aorf_pkg::S_IDLE);

  always_comb begin
    state_d  = state_q;
    ch_d     = ch_q;
    x_d      = x_q;
    v_d      = v_q;
    res_d    = res_q;
    vi_d     = vi_q;
    flag_d   = flag_q;
    pass_d   = pass_q;
    dneg_d   = dneg_q;
    sneg_d   = sneg_q;
    rdv_d    = 1'b0;
    st_d     = st_q;
    dmag_d   = dmag_q;
    n_d      = n_q;
    prod1_d  = prod1_q;
    inc_d    = inc_q;
    wcnt_d   = wcnt_q;
    idx_d    = idx_q;
    i_d      = i_q;
    less_d   = less_q;
    le_d     = le_q;
    sum_d    = sum_q;
    lp_d     = lp_q;
    it_d     = it_q + 6'd1;
    dv_rem_d = dv_rem_nx;
    dv_quo_d = dv_quo_nx;
    dv_dvs_d = dv_dvs_q;
    mu_a_d   = mu_a_q;
    mu_hi_d  = mu_hi_nx;
    mu_lo_d  = mu_lo_nx;
    cs_re    = 1'b0;
    cs_raddr = CH_AW'(s_axis_tdata[2:0]);
    cs_we    = 1'b0;
    cs_wdata = st_q;
    win_re   = 1'b0;
    win_raddr = win_base + WA_W'(idx_q);
    win_we   = 1'b0;
    win_waddr = win_base + WA_W'(slot_nx);

    unique case (state_q)
      aorf_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          ch_d = s_axis_tdata[2:0];
          x_d  = s_axis_tdata[26:3];
          if (int'(s_axis_tdata[2:0]) >= CHANNELS) begin
            // pass through unchanged, touch no state
            res_d   = s_axis_tdata[26:3];
            flag_d  = 1'b0;
            pass_d  = 1'b1;
            state_d = aorf_pkg::S_DONE;
          end else begin
            pass_d  = 1'b0;
            cs_re   = 1'b1;
            state_d = aorf_pkg::S_PREP;
          end
        end
      end

      aorf_pkg::S_PREP: begin
        st_d   = st_v;
        dneg_d = d49[48];
        dmag_d = d49[48] ? 49'(-d49) : d49;
        n_d    = (int'(st_v.cnt) >= MAX_HISTORY) ? CNT_W'(MAX_HISTORY) : st_v.cnt + 1'b1;
        flag_d = lim_hit | grad_hit;
        if (sig_need) begin
          // variance = spread / count
          it_d     = '0;
          dv_rem_d = '0;
          dv_quo_d = st_v.spread;
          dv_dvs_d = DV_W'(st_v.cnt);
          state_d  = aorf_pkg::S_SIG_DIV;
        end else begin
          state_d  = aorf_pkg::S_SEL;
        end
      end

      aorf_pkg::S_SIG_DIV: begin
        if (it_q == aorf_pkg::ITER_LAST) begin
          it_d    = '0;
          mu_a_d  = 64'(dmag_q);
          mu_hi_d = '0;
          mu_lo_d = 64'(dmag_q);
          state_d = aorf_pkg::S_SIG_M1;
        end
      end

      aorf_pkg::S_SIG_M1: begin
        // hold the variance for the second multiply
        dv_quo_d = dv_quo_q;
        if (it_q == aorf_pkg::ITER_LAST) begin
          prod1_d = 98'({mu_hi_nx, mu_lo_nx});
          it_d    = '0;
          mu_a_d  = dv_quo_q;
          mu_hi_d = '0;
          mu_lo_d = 64'(s2);
          state_d = aorf_pkg::S_SIG_M2;
        end
      end

      aorf_pkg::S_SIG_M2: begin
        if (it_q == aorf_pkg::ITER_LAST) begin
          // dev^2 against sigma^2 * var, both Q.32
          flag_d  = {30'd0, prod1_q} > {mu_hi_nx, mu_lo_nx};
          state_d = aorf_pkg::S_SEL;
        end
      end

      aorf_pkg::S_SEL: begin
        v_d      = flag_q ? st_q.last_good : x_q;
        it_d     = '0;
        dv_rem_d = '0;
        dv_quo_d = 64'(dmag_q);
        dv_dvs_d = DV_W'(n_q);
        state_d  = aorf_pkg::S_ST_DIV;
      end

      aorf_pkg::S_ST_DIV: begin
        if (it_q == aorf_pkg::ITER_LAST) begin
          st_d.mean = mean_nx49[47:0];
          state_d   = aorf_pkg::S_ST_D2;
        end
      end

      aorf_pkg::S_ST_D2: begin
        it_d    = '0;
        mu_a_d  = 64'(dmag_q);
        mu_hi_d = '0;
        mu_lo_d = d2_49[48] ? 64'(49'(-d2_49)) : 64'(d2_49);
        state_d = aorf_pkg::S_ST_MUL;
      end

      aorf_pkg::S_ST_MUL: begin
        if (it_q == aorf_pkg::ITER_LAST) begin
          inc_d   = (mu_hi_nx[63:16] != '0) ? '1 : {mu_hi_nx[15:0], mu_lo_nx[63:16]};
          state_d = aorf_pkg::S_ST_ACC;
        end
      end

      aorf_pkg::S_ST_ACC: begin
        st_d.spread = spread_sum65[64] ? '1 : spread_sum65[63:0];
        st_d.cnt    = n_q;
        st_d.slot   = slot_nx;
        st_d.full   = full_nx;
        if (!flag_q) st_d.last_good = x_q;
        win_we  = 1'b1;
        wcnt_d  = full_nx ? WCNT_W'(WINDOW) : WCNT_W'(slot_nx) + 1'b1;
        state_d = aorf_pkg::S_FILT;
      end

      aorf_pkg::S_FILT: begin
        idx_d  = '0;
        sum_d  = '0;
        i_d    = '0;
        res_d  = v_q;
        case (fm_q)
          aorf_pkg::FM_AVG:     state_d = aorf_pkg::S_SCAN;
          aorf_pkg::FM_MEDIAN:  state_d = aorf_pkg::S_MED_RD;
          aorf_pkg::FM_LOWPASS: state_d = aorf_pkg::S_LP_M1;
          default:              state_d = aorf_pkg::S_DONE;
        endcase
      end

      aorf_pkg::S_SCAN: begin
        // issue one read a cycle, consume the data in the cycle after
        if (idx_q != wcnt_q) begin
          win_re = 1'b1;
          idx_d  = idx_q + 1'b1;
          rdv_d  = 1'b1;
        end
        if (rdv_q) begin
          sum_d  = sum_q + {{WCNT_W{win_rdata_q[23]}}, win_rdata_q};
          less_d = less_q + WCNT_W'(win_rdata_q < vi_q);
          le_d   = le_q + WCNT_W'(win_rdata_q <= vi_q);
        end
        if (idx_q == wcnt_q && !rdv_q) begin
          if (fm_q == aorf_pkg::FM_AVG) begin
            sneg_d   = sum_q[SUM_W-1];
            it_d     = '0;
            dv_rem_d = '0;
            dv_quo_d = 64'(sum_mag);
            dv_dvs_d = DV_W'(wcnt_q);
            state_d  = aorf_pkg::S_AVG_DIV;
          end else begin
            state_d  = aorf_pkg::S_MED_CHK;
          end
        end
      end

      aorf_pkg::S_AVG_DIV: begin
        if (it_q == aorf_pkg::ITER_LAST) begin
          res_d   = sneg_q ? q_neg[23:0] : dv_quo_nx[23:0];
          state_d = aorf_pkg::S_DONE;
        end
      end

      aorf_pkg::S_MED_RD: begin
        win_re    = 1'b1;
        win_raddr = win_base + WA_W'(i_q);
        state_d   = aorf_pkg::S_MED_VI;
      end

      aorf_pkg::S_MED_VI: begin
        vi_d    = win_rdata_q;
        idx_d   = '0;
        less_d  = '0;
        le_d    = '0;
        state_d = aorf_pkg::S_SCAN;
      end

      aorf_pkg::S_MED_CHK: begin
        // candidate holds rank k when less <= k < le
        if ((less_q <= med_k && med_k < le_q) || (i_q + 1'b1 == wcnt_q)) begin
          res_d   = vi_q;
          state_d = aorf_pkg::S_DONE;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = aorf_pkg::S_MED_RD;
        end
      end

      aorf_pkg::S_LP_M1: begin
        lp_d    = lp_mul;
        state_d = aorf_pkg::S_LP_M2;
      end

      aorf_pkg::S_LP_M2: begin
        lp_d    = lp_q + lp_mul;
        state_d = aorf_pkg::S_LP_FIN;
      end

      aorf_pkg::S_LP_FIN: begin
        res_d   = lp_adj[39:16];
        state_d = aorf_pkg::S_DONE;
      end

      aorf_pkg::S_DONE: begin
        if (out_load) begin
          if (!pass_q) begin
            cs_we             = 1'b1;
            cs_wdata.prev_raw = x_q;
            cs_wdata.prev_out = res_q;
          end
          state_d = aorf_pkg::S_IDLE;
        end
      end

      default: state_d = aorf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aorf_pkg::S_IDLE;
      chv_q   <= '0;
      rdv_q   <= 1'b0;
      it_q    <= '0;
    end else begin
      state_q <= state_d;
      rdv_q   <= rdv_d;
      it_q    <= it_d;
      if (cs_we) chv_q[ch_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q     <= ch_d;
    x_q      <= x_d;
    v_q      <= v_d;
    res_q    <= res_d;
    vi_q     <= vi_d;
    flag_q   <= flag_d;
    pass_q   <= pass_d;
    dneg_q   <= dneg_d;
    sneg_q   <= sneg_d;
    st_q     <= st_d;
    dmag_q   <= dmag_d;
    n_q      <= n_d;
    prod1_q  <= prod1_d;
    inc_q    <= inc_d;
    wcnt_q   <= wcnt_d;
    idx_q    <= idx_d;
    i_q      <= i_d;
    less_q   <= less_d;
    le_q     <= le_d;
    sum_q    <= sum_d;
    lp_q     <= lp_d;
    dv_rem_q <= dv_rem_d;
    dv_quo_q <= dv_quo_d;
    dv_dvs_q <= dv_dvs_d;
    mu_a_q   <= mu_a_d;
    mu_hi_q  <= mu_hi_d;
    mu_lo_q  <= mu_lo_d;
  end

  // ---------------------------------------------------------------------------
  // Output register: hold the result until the sink takes the beat
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ch_q   <= ch_q;
      out_val_q  <= res_q;
      out_flag_q <= flag_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, out_val_q, out_ch_q};
  assign m_axis_tuser  = out_flag_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("beat accepted while another is in flight");

  a_bypass_direct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && int'(s_axis_tdata[2:0]) >= CHANNELS)
      |=> (state_q == aorf_pkg::S_DONE && pass_q))
    else $error("out-of-range channel did not bypass processing");

  a_state_write_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cs_we |-> (out_load && !pass_q))
    else $error("channel state written outside completion");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == aorf_pkg::S_DONE))
    else $error("result presented without finishing a beat");

endmodule

/* bench/aorf_checker.sv */
module aorf_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,
  input  logic        m_tuser_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [4:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int NCH = 8;
  localparam int WIN = 16;
  localparam int HIST_CAP = 256;
  localparam int SIGMA_MIN = 20;

  typedef struct packed {
    logic [2:0]         chan;
    logic signed [23:0] value;
    logic               flag;
  } filt_beat_t;

  filt_beat_t filt_queue[$];

  // configuration copy
  logic signed [23:0] lim_lo, lim_hi;
  logic [23:0]        step_max;
  logic [15:0]        sig_fac;
  logic [16:0]        lp_weight;
  logic [2:0]         om;
  logic [1:0]         fm;

  // per-channel state copy
  logic signed [23:0] win_mem [NCH][WIN];
  logic [3:0]         slot [NCH];
  logic               full [NCH];
  logic [8:0]         nsamp [NCH];
  logic signed [63:0] mean [NCH];
  logic [63:0]        spread [NCH];
  logic signed [23:0] raw_prev [NCH];
  logic signed [23:0] good_last [NCH];
  logic signed [23:0] out_prev [NCH];

  function automatic logic [63:0] abs64(logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  task automatic clear_state();
    lim_lo = -24'sd8388608;
    lim_hi = 24'sd8388607;
    step_max = 24'hFFFFFF;
    sig_fac = 16'd768;
    lp_weight = 17'd32768;
    om = aorf_pkg::OM_NONE;
    fm = aorf_pkg::FM_NONE;
    for (int c = 0; c < NCH; c++) begin
      slot[c] = 4'(WIN - 1);
      full[c] = 1'b0;
      nsamp[c] = '0;
      mean[c] = '0;
      spread[c] = '0;
      raw_prev[c] = '0;
      good_last[c] = '0;
      out_prev[c] = '0;
      for (int k = 0; k < WIN; k++) win_mem[c][k] = '0;
    end
  endtask

  function automatic logic sigma_reject(int c, logic signed [63:0] xs);
    logic [63:0]  var_q, dev, s2;
    logic [127:0] lhs, rhs;
    if (nsamp[c] < SIGMA_MIN) return 1'b0;
    var_q = spread[c] / 64'(nsamp[c]);
    dev = abs64(xs - mean[c]);
    s2 = 64'(sig_fac) * 64'(sig_fac);
    lhs = 128'(dev) * 128'(dev);
    rhs = 128'(s2) * 128'(var_q);
    return lhs > rhs;
  endfunction

  // Welford update; every raw sample counts, outliers too
  task automatic track_stats(int c, logic signed [63:0] xs);
    logic signed [63:0] d, d2;
    logic [63:0]        n, inc;
    logic [127:0]       prod;
    logic [64:0]        acc;
    if (nsamp[c] >= HIST_CAP) n = HIST_CAP;
    else begin
      nsamp[c] = nsamp[c] + 1;
      n = 64'(nsamp[c]);
    end
    d = xs - mean[c];
    mean[c] = mean[c] + d / $signed(n);
    d2 = xs - mean[c];
    prod = 128'(abs64(d)) * 128'(abs64(d2));
    inc = (prod[127:80] != 0) ? '1 : prod[79:16];
    acc = 65'(spread[c]) + 65'(inc);
    spread[c] = acc[64] ? '1 : acc[63:0];
  endtask

  function automatic logic signed [23:0] upper_median(int c, int cnt);
    int k, below, atmost;
    k = cnt / 2;
    for (int i = 0; i < cnt; i++) begin
      below = 0;
      atmost = 0;
      for (int j = 0; j < cnt; j++) begin
        if (win_mem[c][j] < win_mem[c][i]) below++;
        if (win_mem[c][j] <= win_mem[c][i]) atmost++;
      end
      if (below <= k && k < atmost) return win_mem[c][i];
    end
    return win_mem[c][0];
  endfunction

  task automatic filter_sample(logic [2:0] c, logic signed [23:0] x);
    filt_beat_t         exp_beat;
    logic               flag;
    logic signed [63:0] xs, v, res, sum, w, num;
    int                 cnt;
    flag = 1'b0;
    xs = 64'(x) * 65536;
    if ((om == aorf_pkg::OM_LIMIT || om == aorf_pkg::OM_ALL) &&
        (x < lim_lo || x > lim_hi)) flag = 1'b1;
    if (!flag && (om == aorf_pkg::OM_GRAD || om == aorf_pkg::OM_ALL) && nsamp[c] > 0 &&
        abs64(64'(x) - 64'(raw_prev[c])) > 64'(step_max)) flag = 1'b1;
    if (!flag && (om == aorf_pkg::OM_SIGMA || om == aorf_pkg::OM_ALL))
      flag = sigma_reject(c, xs);
    if (flag) v = 64'(good_last[c]);
    else begin
      v = 64'(x);
      good_last[c] = x;
    end
    track_stats(c, xs);
    slot[c] = slot[c] + 1;
    win_mem[c][slot[c]] = v[23:0];
    if (slot[c] == 4'(WIN - 1)) full[c] = 1'b1;
    cnt = full[c] ? WIN : int'(slot[c]) + 1;
    res = v;
    case (fm)
      aorf_pkg::FM_AVG: begin
        sum = 0;
        for (int i = 0; i < cnt; i++) sum = sum + 64'(win_mem[c][i]);
        res = sum / cnt;
      end
      aorf_pkg::FM_MEDIAN: res = 64'(upper_median(c, cnt));
      aorf_pkg::FM_LOWPASS: begin
        // weights above unity clamp to unity
        w = (lp_weight > 17'd65536) ? 65536 : 64'(lp_weight);
        num = w * v + (65536 - w) * 64'(out_prev[c]);
        res = num / 65536;
      end
      default: ;
    endcase
    raw_prev[c] = x;
    out_prev[c] = res[23:0];
    exp_beat.chan = c;
    exp_beat.value = res[23:0];
    exp_beat.flag = flag;
    filt_queue.push_back(exp_beat);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    filt_beat_t want;
    if (!rst_ni) begin
      clear_state();
      filt_queue.delete();
      fail_count_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (aorf_pkg::reg_idx_e'(paddr_i[4:2]))
          aorf_pkg::REG_LIMIT_LOW:   lim_lo = pwdata_i[23:0];
          aorf_pkg::REG_LIMIT_HIGH:  lim_hi = pwdata_i[23:0];
          aorf_pkg::REG_STEP_THRESH: step_max = pwdata_i[23:0];
          aorf_pkg::REG_SIGMA:       sig_fac = pwdata_i[15:0];
          aorf_pkg::REG_WEIGHT:      lp_weight = pwdata_i[16:0];
          aorf_pkg::REG_OUTLIER:     om = pwdata_i[2:0];
          aorf_pkg::REG_FILTER:      fm = pwdata_i[1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) filter_sample(s_tdata_i[2:0], s_tdata_i[26:3]);
      if (m_tvalid_i && m_tready_i) begin
        if (filt_queue.size() == 0) begin
          $error("output beat with no prediction pending: tdata %h", m_tdata_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = filt_queue.pop_front();
          if (m_tdata_i[2:0] !== want.chan ||
              $signed(m_tdata_i[26:3]) !== want.value ||
              m_tuser_i !== want.flag || m_tdata_i[31:27] !== '0)
            fail_count_o <= fail_count_o + 1;
          if (m_tdata_i[2:0] !== want.chan)
            $error("out_channel: expected %0d, got %0d", want.chan, m_tdata_i[2:0]);
          if ($signed(m_tdata_i[26:3]) !== want.value)
            $error("filtered_result: expected %0d, got %0d", want.value,
                   $signed(m_tdata_i[26:3]));
          if (m_tuser_i !== want.flag)
            $error("outlier_flag: expected %0d, got %0d", want.flag, m_tuser_i);
          if (m_tdata_i[31:27] !== '0)
            $error("tdata pad: expected 0, got %h", m_tdata_i[31:27]);
        end
      end
    end
    pending_o <= filt_queue.size();
  end

endmodule

/* bench/tb.sv */
module tb;

  localparam int STALL_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [2:0] channel, [26:3] sample, [31:27] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [2:0] out_channel, [26:3] filtered_result, [31:27] zero
  logic        m_axis_tuser;        // [0] outlier_flag
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int   fail_count, pending;
  bit   calm = 1'b0;           // no stalls on either side in the closing stretch
  int   idle_cycles = 0;
  logic signed [23:0] base_level [8];

  always #4 clk_i = ~clk_i;

  adc_outlier_reject_and_filter dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  aorf_checker u_checker (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready), .s_tdata_i(s_axis_tdata),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_i(m_axis_tdata),
    .m_tuser_i(m_axis_tuser),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Sink side: hold tready low in random bursts, never once calm
  initial begin
    @(posedge rst_ni);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      if (!calm && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  // Watchdog: end the run if no beat moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Setup cycle, then access cycle; the register takes the value at the access edge
  task automatic write_reg(aorf_pkg::reg_idx_e idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Present one sample and hold it until the block takes it, then maybe idle
  task automatic send_sample(logic [2:0] ch, logic signed [23:0] x);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, x, ch};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drain all pending predictions before touching the registers
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Mostly a noisy level per channel, with spikes and fully random words mixed in
  function automatic logic signed [23:0] pick_sample(logic [2:0] ch);
    int r;
    r = $urandom_range(0, 99);
    if (r < 78) return base_level[ch] + 24'($signed($urandom_range(0, 2000)) - 1000);
    if (r < 90) return base_level[ch] + 24'($signed($urandom_range(0, 400000)) - 200000);
    return 24'($urandom);
  endfunction

  initial begin
    logic [16:0] wt;
    logic [15:0] sf;
    logic [23:0] st, lo, hi;
    for (int c = 0; c < 8; c++) base_level[c] = 24'($signed($urandom_range(0, 2000000)) - 1000000);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, field extremes on channels 0, 7 and 3
    send_sample(3'd0, -24'sd8388608);
    send_sample(3'd0, 24'sd8388607);
    send_sample(3'd7, 24'sd8388607);
    send_sample(3'd7, -24'sd8388608);
    send_sample(3'd3, 24'sd0);
    send_sample(3'd3, -24'sd1);
    wait_drained();
    // Limit check against tight bounds, median filter on swings across the bounds
    write_reg(aorf_pkg::REG_LIMIT_LOW, 32'(24'(-24'sd1000)));
    write_reg(aorf_pkg::REG_LIMIT_HIGH, 32'(24'sd1000));
    write_reg(aorf_pkg::REG_OUTLIER, 32'(aorf_pkg::OM_LIMIT));
    write_reg(aorf_pkg::REG_FILTER, 32'(aorf_pkg::FM_MEDIAN));
    send_sample(3'd1, 24'sd999);
    send_sample(3'd1, 24'sd1001);
    send_sample(3'd1, -24'sd1001);
    send_sample(3'd1, -24'sd1000);
    send_sample(3'd2, 24'sd8388607);
    wait_drained();
    // Gradient check with zero threshold, low-pass with a weight above unity
    write_reg(aorf_pkg::REG_STEP_THRESH, 32'd0);
    write_reg(aorf_pkg::REG_OUTLIER, 32'(aorf_pkg::OM_GRAD));
    write_reg(aorf_pkg::REG_WEIGHT, 32'h1FFFF);
    write_reg(aorf_pkg::REG_FILTER, 32'(aorf_pkg::FM_LOWPASS));
    send_sample(3'd4, 24'sd5);
    send_sample(3'd4, 24'sd5);
    send_sample(3'd4, 24'sd6);
    send_sample(3'd5, -24'sd8388608);
    send_sample(3'd5, 24'sd8388607);
    wait_drained();
    // Unknown outlier mode acts as no check; moving average over swings
    write_reg(aorf_pkg::REG_OUTLIER, 32'd7);
    write_reg(aorf_pkg::REG_FILTER, 32'(aorf_pkg::FM_AVG));
    write_reg(aorf_pkg::REG_WEIGHT, 32'd0);
    send_sample(3'd6, 24'sd8388607);
    send_sample(3'd6, -24'sd8388608);
    send_sample(3'd6, 24'sd1234);
    wait_drained();

    // Random phases, each with its own register set, extremes mixed in
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 11) calm = 1'b1;
      case (ph % 4)
        0: wt = 17'd0;
        1: wt = 17'd65536;
        2: wt = 17'h1FFFF;
        default: wt = 17'($urandom_range(0, 131071));
      endcase
      case (ph % 5)
        0: sf = 16'd0;
        1: sf = 16'hFFFF;
        2: sf = 16'd256;
        3: sf = 16'd768;
        default: sf = 16'($urandom);
      endcase
      case (ph % 3)
        0: st = 24'hFFFFFF;
        1: st = 24'd0;
        default: st = 24'($urandom_range(500, 300000));
      endcase
      if (ph % 3 == 0) begin
        lo = 24'h800000;
        hi = 24'h7FFFFF;
      end else begin
        lo = 24'($signed($urandom_range(0, 3000000)) - 3000000);
        hi = 24'($urandom_range(0, 3000000));
      end
      write_reg(aorf_pkg::REG_LIMIT_LOW, 32'(lo));
      write_reg(aorf_pkg::REG_LIMIT_HIGH, 32'(hi));
      write_reg(aorf_pkg::REG_STEP_THRESH, 32'(st));
      write_reg(aorf_pkg::REG_SIGMA, 32'(sf));
      write_reg(aorf_pkg::REG_WEIGHT, 32'(wt));
      write_reg(aorf_pkg::REG_OUTLIER, 32'((ph + 3) % 8));
      write_reg(aorf_pkg::REG_FILTER, 32'(ph % 4));
      for (int i = 0; i < 96; i++) begin
        logic [2:0] ch;
        ch = 3'($urandom_range(0, 7));
        send_sample(ch, pick_sample(ch));
      end
      wait_drained();
    end

    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* sim.f */
design/aorf_pkg.sv
design/adc_outlier_reject_and_filter.sv
bench/aorf_checker.sv
bench/tb.sv
